>>> hdl/nsf_pkg.sv
// Package for the NMEA sentence filter: payload structs, register indexes,
// checksum phase and verdict codes. No dependencies.
package nsf_pkg;

  localparam logic [7:0]  StarByte        = 8'h2A;
  localparam logic [2:0]  HeaderLen       = 3'd6;
  localparam logic [7:0]  DelimiterReset  = 8'd44;
  localparam logic [47:0] HeaderReset     = 48'd39888708126529;

  typedef enum logic {
    REG_FIELD_DELIMITER = 1'b0,
    REG_EXPECTED_HEADER = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    PH_BEFORE_STAR = 2'd0,
    PH_DIGIT_HI    = 2'd1,
    PH_DIGIT_LO    = 2'd2,
    PH_DONE        = 2'd3
  } cks_phase_e;

  typedef enum logic [1:0] {
    VERDICT_OK         = 2'd0,
    VERDICT_BAD_HEADER = 2'd1,
    VERDICT_BAD_CKS    = 2'd2,
    VERDICT_EMPTY      = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] verdict;
  } out_item_t;

endpackage

>>> hdl/nmea_sentence_filter.sv
// NMEA sentence filter: checks header, checksum and empty-field pairs of one
// line of text that arrives one byte per item. Depends on nsf_pkg.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_data_i) carries one byte of
//   the line per item, with end_of_line set on the last byte. The output
//   channel (out_valid_o/out_ready_i/out_data_o) carries one verdict item per
//   line, produced by the byte flagged end_of_line.
//   The configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i)
//   writes the field delimiter (index 0) or the expected header (index 1);
//   it is always ready and should only be used between lines.
//   Throughput is one byte per cycle unless a line-ending byte waits (below).
//   The per-line state is updated in the cycle a byte is accepted, and the
//   verdict sits in the output register in the cycle after the last byte.
//   When the receiver stalls, bytes that do not end a line are still taken;
//   a line-ending byte waits only while a previous verdict is still held and
//   not being taken in the same cycle.
//   Reset clears all line state and the output valid flag, and loads the
//   default delimiter (comma) and header ($GPGGA).
module nmea_sentence_filter
  import nsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  reg_index_e  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [7:0]  delim_q;
  logic [47:0] header_q;

  logic [2:0]  pos_q, pos_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic [7:0]  xor_q, xor_d;
  cks_phase_e  phase_q, phase_d;
  logic [7:0]  rx_cks_q, rx_cks_d;
  logic        hex_err_q, hex_err_d;
  logic        prev_delim_q, prev_delim_d;
  logic [1:0]  pairs_q, pairs_d;

  logic        out_valid_q;
  out_item_t   out_data_q;

  logic        in_fire;
  logic [7:0]  byte_b;
  logic [7:0]  want_b;
  logic        digit_ok;
  logic [3:0]  digit_val;
  verdict_e    verdict;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !(out_valid_q && !out_ready_i && in_data_i.end_of_line);
  assign in_fire     = in_valid_i && in_ready_o;
  assign byte_b      = in_data_i.line_byte;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    unique case (pos_q)
      3'd0:    want_b = header_q[47:40];
      3'd1:    want_b = header_q[39:32];
      3'd2:    want_b = header_q[31:24];
      3'd3:    want_b = header_q[23:16];
      3'd4:    want_b = header_q[15:8];
      default: want_b = header_q[7:0];
    endcase
  end

  always_comb begin
    digit_ok  = 1'b1;
    digit_val = 4'd0;
    if (byte_b >= 8'h30 && byte_b <= 8'h39) begin
      digit_val = byte_b[3:0];
    end else if ((byte_b >= 8'h41 && byte_b <= 8'h46) ||
                 (byte_b >= 8'h61 && byte_b <= 8'h66)) begin
      // 'A'..'F' and 'a'..'f' have low nibble 1..6, i.e. value minus 9.
      digit_val = byte_b[3:0] + 4'd9;
    end else begin
      digit_ok  = 1'b0;
    end
  end

  always_comb begin
    pos_d        = pos_q;
    hdr_bad_d    = hdr_bad_q;
    xor_d        = xor_q;
    phase_d      = phase_q;
    rx_cks_d     = rx_cks_q;
    hex_err_d    = hex_err_q;
    prev_delim_d = 1'b0;
    pairs_d      = pairs_q;

    if (pos_q < HeaderLen) begin
      if (want_b != byte_b) begin
        hdr_bad_d = 1'b1;
      end
      pos_d = pos_q + 3'd1;
    end

    // The first byte is the start mark and takes no part in the checksum.
    if (pos_q != 3'd0) begin
      unique case (phase_q)
        PH_BEFORE_STAR: begin
          if (byte_b == StarByte) begin
            phase_d = PH_DIGIT_HI;
          end else begin
            xor_d = xor_q ^ byte_b;
          end
        end
        PH_DIGIT_HI, PH_DIGIT_LO: begin
          if (!digit_ok) begin
            hex_err_d = 1'b1;
          end else begin
            rx_cks_d = {rx_cks_q[3:0], digit_val};
          end
          phase_d = (phase_q == PH_DIGIT_HI) ? PH_DIGIT_LO : PH_DONE;
        end
        default: ;
      endcase
    end

    // Pairs do not overlap: the second delimiter of a pair starts no new one.
    if (byte_b == delim_q) begin
      if (prev_delim_q) begin
        if (pairs_q < 2'd2) begin
          pairs_d = pairs_q + 2'd1;
        end
      end else begin
        prev_delim_d = 1'b1;
      end
    end

    priority if (hdr_bad_d || pos_d < HeaderLen) begin
      verdict = VERDICT_BAD_HEADER;
    end else if (phase_d != PH_DONE || hex_err_d || rx_cks_d != xor_d) begin
      verdict = VERDICT_BAD_CKS;
    end else if (pairs_d > 2'd1) begin
      verdict = VERDICT_EMPTY;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= DelimiterReset;
      header_q <= HeaderReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FIELD_DELIMITER: delim_q  <= cfg_data_i[7:0];
        REG_EXPECTED_HEADER: header_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 3'd0;
      hdr_bad_q    <= 1'b0;
      xor_q        <= 8'd0;
      phase_q      <= PH_BEFORE_STAR;
      rx_cks_q     <= 8'd0;
      hex_err_q    <= 1'b0;
      prev_delim_q <= 1'b0;
      pairs_q      <= 2'd0;
    end else if (in_fire) begin
      if (in_data_i.end_of_line) begin
        pos_q        <= 3'd0;
        hdr_bad_q    <= 1'b0;
        xor_q        <= 8'd0;
        phase_q      <= PH_BEFORE_STAR;
        rx_cks_q     <= 8'd0;
        hex_err_q    <= 1'b0;
        prev_delim_q <= 1'b0;
        pairs_q      <= 2'd0;
      end else begin
        pos_q        <= pos_d;
        hdr_bad_q    <= hdr_bad_d;
        xor_q        <= xor_d;
        phase_q      <= phase_d;
        rx_cks_q     <= rx_cks_d;
        hex_err_q    <= hex_err_d;
        prev_delim_q <= prev_delim_d;
        pairs_q      <= pairs_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && in_data_i.end_of_line) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.end_of_line) begin
      out_data_q.accepted <= (verdict == VERDICT_OK);
      out_data_q.verdict  <= verdict;
    end
  end

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= HeaderLen)
    else $error("byte position ran past the header length");

  a_verdict_follows_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_line |=> out_valid_q && pos_q == 3'd0)
    else $error("line end did not produce a verdict and clear the line");

  a_accept_matches_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.accepted == (out_data_q.verdict == VERDICT_OK))
    else $error("accepted flag disagrees with verdict");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && in_data_i.end_of_line))
    else $error("verdict appeared without a line end");

endmodule

>>> test/nmea_sentence_filter_tb.sv
// Self-checking testbench for nmea_sentence_filter: sends sentences byte by byte and
// checks each line verdict against an in-bench prediction of header, checksum and
// empty-field rules. Depends on nsf_pkg and the nmea_sentence_filter RTL.
module nmea_sentence_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsf_pkg::*;

  localparam int WatchdogLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_index_e  cfg_index = REG_FIELD_DELIMITER;
  logic [47:0] cfg_data = '0;

  // Register copies, updated when a configuration write is accepted.
  logic [7:0]  delim_reg = DelimiterReset;
  logic [47:0] header_reg = HeaderReset;

  // Per-line state of the prediction.
  logic [2:0]  pos_cnt = '0;
  logic        hdr_bad = 1'b0;
  logic [7:0]  xor_acc = '0;
  cks_phase_e  cks_phase = PH_BEFORE_STAR;
  logic [7:0]  cks_rx = '0;
  logic        hex_bad = 1'b0;
  logic        prev_delim = 1'b0;
  logic [1:0]  pair_cnt = '0;

  in_item_t    byte_q[$];
  out_item_t   verdict_q[$];
  logic [7:0]  line_buf[$];
  int          queued = 0;
  int          err_cnt = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  out_item_t   want;

  nmea_sentence_filter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "A" && c <= "F") v = c - "A" + 8'd10;
    else if (c >= "a" && c <= "f") v = c - "a" + 8'd10;
    return {v < 8'd16, v[3:0]};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return 8'h30 + v;
    return (lower ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  // Checksum over the line built so far: every byte after the first, up to a star.
  function automatic logic [7:0] line_xor();
    logic [7:0] x;
    x = '0;
    for (int i = 1; i < line_buf.size(); i++) begin
      if (line_buf[i] == StarByte) break;
      x ^= line_buf[i];
    end
    return x;
  endfunction

  task automatic scan_byte(input in_item_t it);
    logic [7:0] b;
    logic       first;
    logic [4:0] hd;
    out_item_t  res;
    b = it.line_byte;
    first = (pos_cnt == 3'd0);
    if (pos_cnt < HeaderLen) begin
      if (header_reg[8 * (5 - int'(pos_cnt)) +: 8] != b) hdr_bad = 1'b1;
      pos_cnt++;
    end
    if (!first) begin
      case (cks_phase)
        PH_BEFORE_STAR: begin
          if (b == StarByte) cks_phase = PH_DIGIT_HI;
          else xor_acc ^= b;
        end
        PH_DIGIT_HI, PH_DIGIT_LO: begin
          hd = hex_digit(b);
          if (!hd[4]) hex_bad = 1'b1;
          else cks_rx = {cks_rx[3:0], hd[3:0]};
          cks_phase = cks_phase_e'(cks_phase + 2'd1);
        end
        default: ;
      endcase
    end
    // A run of n delimiters counts n/2 pairs, rounded down, up to two pairs.
    if (b == delim_reg) begin
      if (prev_delim) begin
        if (pair_cnt < 2'd2) pair_cnt++;
        prev_delim = 1'b0;
      end else begin
        prev_delim = 1'b1;
      end
    end else begin
      prev_delim = 1'b0;
    end
    if (it.end_of_line) begin
      if (hdr_bad || pos_cnt < HeaderLen) res.verdict = VERDICT_BAD_HEADER;
      else if (cks_phase != PH_DONE || hex_bad || cks_rx != xor_acc)
        res.verdict = VERDICT_BAD_CKS;
      else if (pair_cnt > 2'd1) res.verdict = VERDICT_EMPTY;
      else res.verdict = VERDICT_OK;
      res.accepted = (res.verdict == VERDICT_OK);
      verdict_q.push_back(res);
      pos_cnt = '0;
      hdr_bad = 1'b0;
      xor_acc = '0;
      cks_phase = PH_BEFORE_STAR;
      cks_rx = '0;
      hex_bad = 1'b0;
      prev_delim = 1'b0;
      pair_cnt = '0;
    end
  endtask

  // Sender of line bytes.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) scan_byte(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && !quiet && byte_q.size() != 0 && $urandom_range(0, 11) == 0)
          gap_left = $urandom_range(1, 19);
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver of verdicts.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict item: expected none, got accepted=%0b verdict=%0d",
                   $time, out_data.accepted, out_data.verdict);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %0b, got %0b",
                     $time, want.accepted, out_data.accepted);
            err_cnt++;
          end
          if (out_data.verdict !== want.verdict) begin
            $display("%0t: verdict mismatch: expected %0d, got %0d",
                     $time, want.verdict, out_data.verdict);
            err_cnt++;
          end
        end
      end
      if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 19);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_header(input int n);
    for (int i = 0; i < n; i++) line_buf.push_back(header_reg[8 * (5 - i) +: 8]);
  endtask

  task automatic add_star_digits(input logic [7:0] value, input bit lower);
    line_buf.push_back(StarByte);
    line_buf.push_back(hex_char(value[7:4], lower));
    line_buf.push_back(hex_char(value[3:0], lower));
  endtask

  // Field text that never holds a star, so the checksum stays where it is put.
  task automatic add_body(input int n, input int dpct);
    int         r;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r >= 97) begin
        repeat ($urandom_range(2, 5)) line_buf.push_back(delim_reg);
      end else if (r < dpct) begin
        line_buf.push_back(delim_reg);
      end else begin
        do begin
          c = (r < dpct + 10) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
        end while (c == StarByte);
        line_buf.push_back(c);
      end
    end
  endtask

  task automatic send_line();
    in_item_t it;
    for (int i = 0; i < line_buf.size(); i++) begin
      it.line_byte = line_buf[i];
      it.end_of_line = (i == line_buf.size() - 1);
      byte_q.push_back(it);
    end
    queued += line_buf.size();
    line_buf.delete();
  endtask

  // Waits until every byte is taken and every verdict has come back.
  task automatic drain();
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_index_e idx, input logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FIELD_DELIMITER) delim_reg = val[7:0];
    else header_reg = val;
  endtask

  task automatic gen_line();
    int         kind;
    int         n;
    logic [7:0] c;
    logic [7:0] cks;
    logic [4:0] hd;
    bit         lower;
    kind = $urandom_range(0, 99);
    lower = $urandom_range(0, 1);
    if (kind >= 90) begin
      // Short header prefixes and raw noise.
      if (kind < 95) add_header($urandom_range(1, 5));
      else repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
      send_line();
      return;
    end
    add_header(6);
    if (kind >= 60 && kind < 67) begin
      n = $urandom_range(0, 5);
      line_buf[n] ^= 8'($urandom_range(1, 255));
    end
    add_body($urandom_range(0, 16), 10 * $urandom_range(0, 3));
    if (kind >= 74 && kind < 79) begin
      send_line();
      return;
    end
    cks = line_xor();
    if (kind >= 67 && kind < 74) cks ^= 8'($urandom_range(1, 255));
    add_star_digits(cks, lower);
    if (kind >= 79 && kind < 84) begin
      void'(line_buf.pop_back());
      if ($urandom_range(0, 1)) void'(line_buf.pop_back());
    end else if (kind >= 84) begin
      do begin
        c = 8'($urandom_range(0, 255));
        hd = hex_digit(c);
      end while (hd[4]);
      line_buf[line_buf.size() - 1 - $urandom_range(0, 1)] = c;
    end
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: line_buf.push_back(8'h0D);
          1: line_buf.push_back(8'h0A);
          2: line_buf.push_back(delim_reg);
          default: line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    send_line();
  endtask

  task automatic random_phase(input logic [7:0] delim, input logic [47:0] hdr,
                              input int nbytes);
    int target;
    drain();
    if ($urandom_range(0, 1)) begin
      cfg_write(REG_FIELD_DELIMITER, {$urandom(), 8'($urandom()), delim});
      cfg_write(REG_EXPECTED_HEADER, hdr);
    end else begin
      cfg_write(REG_EXPECTED_HEADER, hdr);
      cfg_write(REG_FIELD_DELIMITER, {$urandom(), 8'($urandom()), delim});
    end
    target = queued + nbytes;
    while (queued < target) gen_line();
  endtask

  initial begin
    string bad_digits;
    bad_digits = "/:@G`g";
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines under the reset header and delimiter.
    add_str("$GPGGA");
    add_star_digits(line_xor(), 1'b1);
    send_line();
    add_str("$GPGGA,,1");
    add_star_digits(line_xor(), 1'b0);
    send_line();
    // Three delimiters in a row still make only one pair.
    add_str("$GPGGA,,,2");
    add_star_digits(line_xor(), 1'b0);
    send_line();
    add_str("$GPGGA,,,,3");
    add_star_digits(line_xor(), 1'b0);
    send_line();
    add_str("$GPGGA,,1,,2");
    add_star_digits(line_xor(), 1'b1);
    send_line();
    add_str("$GPGGA,5");
    add_star_digits(line_xor(), 1'b0);
    add_str("\r\n");
    send_line();
    // Delimiters after the digits still count toward pairs.
    add_str("$GPGGA,,7");
    add_star_digits(line_xor(), 1'b0);
    add_str(",,");
    send_line();
    add_str("$GPGGA,");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    line_buf.push_back(8'h7F);
    add_star_digits(line_xor(), 1'b0);
    send_line();
    add_str("$");
    send_line();
    add_str("$GPGG");
    send_line();
    add_str("$GPGGB,1");
    add_star_digits(line_xor(), 1'b0);
    send_line();
    // Header and checksum both wrong: the header verdict wins.
    add_str("*GPGGA*00");
    send_line();
    add_str("$GPGGA,1,2");
    send_line();
    add_str("$GPGGA*");
    send_line();
    add_str("$GPGGA*4");
    send_line();
    for (int k = 0; k < bad_digits.len(); k++) begin
      add_str("$GPGGA*");
      if (k < 3) begin
        line_buf.push_back(bad_digits[k]);
        line_buf.push_back("0");
      end else begin
        line_buf.push_back("4");
        line_buf.push_back(bad_digits[k]);
      end
      send_line();
    end
    add_str("$GPGGA,9");
    add_star_digits(line_xor() ^ 8'h01, 1'b0);
    send_line();

    random_phase(DelimiterReset, HeaderReset, 380);
    random_phase(";", "$GNRMC", 330);
    random_phase(8'hFF, 48'h0, 300);
    random_phase(8'h00, 48'hFFFF_FFFF_FFFF, 300);
    quiet = 1'b1;
    random_phase(DelimiterReset, HeaderReset, 300);
    drain();
    repeat (4) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> nmea_sentence_filter.f
hdl/nsf_pkg.sv
hdl/nmea_sentence_filter.sv
test/nmea_sentence_filter_tb.sv
